[rtl/gtp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtp_pkg: shared constants and types for the gradient test pattern unit
// Coordinate and register widths, divider widths and register indexes.
// ----------------------------------------------------------------------------
package gtp_pkg;

  localparam int COORD_BITS = 12;
  // x*255 needs eight more bits than the coordinate
  localparam int DIVD_BITS  = COORD_BITS + 8;
  // width+height divisor needs one more bit
  localparam int DIVS_BITS  = COORD_BITS + 1;
  localparam int PIX_BITS   = 32;
  localparam int CFG_BITS   = COORD_BITS;
  localparam int IDX_BITS   = 2;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [PIX_BITS-1:0]   pixel_t;
  typedef logic [IDX_BITS-1:0]   cfg_idx_t;
  typedef logic [CFG_BITS-1:0]   cfg_data_t;

  localparam cfg_idx_t REG_FRAME_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_FRAME_HEIGHT = 2'd1;
  localparam cfg_idx_t REG_PIXEL_FORMAT = 2'd2;

  localparam coord_t RST_FRAME_WIDTH  = COORD_BITS'(640);
  localparam coord_t RST_FRAME_HEIGHT = COORD_BITS'(480);

  localparam logic FMT_RGB565   = 1'b0;
  localparam logic FMT_XRGB8888 = 1'b1;

  // one lane of the bit-serial divider pipeline
  typedef struct packed {
    logic [DIVD_BITS-1:0] num;
    logic [DIVD_BITS-1:0] quo;
    logic [DIVS_BITS-1:0] rem;
  } div_lane_t;

endpackage

[rtl/gtp_coord_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtp_coord_if: pixel coordinate channel
// Valid/ready channel carrying one coordinate pair per transfer.
// ----------------------------------------------------------------------------
interface gtp_coord_if;
  import gtp_pkg::*;
  logic   valid;
  logic   ready;
  coord_t pos_x;
  coord_t pos_y;
  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

[rtl/gtp_pixel_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtp_pixel_if: packed pixel channel
// Valid/ready channel carrying one packed colour word per transfer.
// ----------------------------------------------------------------------------
interface gtp_pixel_if;
  import gtp_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t pixel_value;
  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

[rtl/gradient_test_pattern_pixel_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_test_pattern_pixel_unit: gradient test pattern pixel generator
// Red, green and blue quotients from three bit-serial pipelined dividers,
// packed as RGB565 or XRGB8888.
//
//   channel   dir  transfer carries
//   coord_in  in   pos_x, pos_y
//   pixel_out out  pixel_value
//   cfg       in   wr_en_i, wr_idx_i, wr_data_i (no handshake)
//
// One pixel per clock while the output word is taken; 20 divider stages,
// one quotient bit each, plus the dividend register and the output register.
// Reset restores 640x480 RGB565 and empties the pipeline.
// The whole pipeline advances together; it holds while the output word
// waits, and input ready follows that hold.
// ----------------------------------------------------------------------------
module gradient_test_pattern_pixel_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  gtp_pkg::cfg_idx_t   wr_idx_i,
  input  gtp_pkg::cfg_data_t  wr_data_i,
  gtp_coord_if.sink           coord_in,
  gtp_pixel_if.source         pixel_out
);
  import gtp_pkg::*;

  localparam int NSTG = DIVD_BITS;

  coord_t fw_q, fh_q;
  logic   fmt_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= RST_FRAME_WIDTH;
      fh_q  <= RST_FRAME_HEIGHT;
      fmt_q <= FMT_RGB565;
    end else if (wr_en_i) begin
      unique case (wr_idx_i)
        REG_FRAME_WIDTH:  fw_q  <= wr_data_i[COORD_BITS-1:0];
        REG_FRAME_HEIGHT: fh_q  <= wr_data_i[COORD_BITS-1:0];
        REG_PIXEL_FORMAT: fmt_q <= wr_data_i[0];
        default: ;
      endcase
    end
  end

  // divisors, zero taken as one; the user must keep them stable while items are in flight (not enforced here)
  logic [DIVS_BITS-1:0] div_w, div_h, div_s, sum;
  assign sum   = {1'b0, fw_q} + {1'b0, fh_q};
  assign div_w = (fw_q == '0) ? DIVS_BITS'(1) : {1'b0, fw_q};
  assign div_h = (fh_q == '0) ? DIVS_BITS'(1) : {1'b0, fh_q};
  assign div_s = (sum  == '0) ? DIVS_BITS'(1) : sum;

  logic adv;
  logic out_vld_q;
  pixel_t out_q;
  assign adv             = !out_vld_q || pixel_out.ready;
  assign coord_in.ready  = adv;
  assign pixel_out.valid = out_vld_q;
  assign pixel_out.pixel_value = out_q;

  // one restoring division step
  function automatic div_lane_t div_step(div_lane_t l, logic [DIVS_BITS-1:0] d);
    logic [DIVS_BITS:0] r;
    div_lane_t          o;
    r     = {l.rem, l.num[DIVD_BITS-1]};
    o.num = {l.num[DIVD_BITS-2:0], 1'b0};
    if (r >= {1'b0, d}) begin
      r     = r - {1'b0, d};
      o.quo = {l.quo[DIVD_BITS-2:0], 1'b1};
    end else begin
      o.quo = {l.quo[DIVD_BITS-2:0], 1'b0};
    end
    o.rem = r[DIVS_BITS-1:0];
    return o;
  endfunction

  // x*255 = (x<<8) - x
  function automatic logic [DIVD_BITS-1:0] times255(logic [COORD_BITS-1:0] v);
    return {v, 8'd0} - DIVD_BITS'(v);
  endfunction

  div_lane_t r_q [0:NSTG];
  div_lane_t g_q [0:NSTG];
  div_lane_t b_q [0:NSTG];
  logic      vld_q [0:NSTG];

  // dividend stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= coord_in.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q[0] <= '{num: times255(coord_in.pos_x), quo: '0, rem: '0};
      g_q[0] <= '{num: times255(coord_in.pos_y), quo: '0, rem: '0};
      b_q[0] <= '{num: times255(coord_in.pos_x ^ coord_in.pos_y), quo: '0, rem: '0};
    end
  end

  // divider stages, one quotient bit each
  for (genvar s = 1; s <= NSTG; s++) begin : g_stg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        r_q[s] <= div_step(r_q[s-1], div_w);
        g_q[s] <= div_step(g_q[s-1], div_h);
        b_q[s] <= div_step(b_q[s-1], div_s);
      end
    end
  end

  // packing
  pixel_t red, grn, blu, word;
  assign red = PIX_BITS'(r_q[NSTG].quo);
  assign grn = PIX_BITS'(g_q[NSTG].quo);
  assign blu = PIX_BITS'(b_q[NSTG].quo);
  always_comb begin
    if (fmt_q == FMT_XRGB8888) begin
      word = 32'hff00_0000 | (red << 16) | (grn << 8) | blu;
    end else begin
      word = (((red & 32'h0f8) << 8) | ((grn & 32'h0fc) << 3) | (blu >> 3))
             & 32'h0000_ffff;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[NSTG];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= word;
    end
  end

endmodule

[dv/tb_gradient_test_pattern_pixel_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gradient_test_pattern_pixel_unit: testbench for the gradient pattern unit
// Drives coordinate pairs through the valid/ready channel under several frame
// sizes and both pixel formats, predicts each packed colour in the bench and
// compares every output transfer in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_gradient_test_pattern_pixel_unit;
  import gtp_pkg::*;

  localparam int LATENCY  = DIVD_BITS + 2;
  localparam int WD_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic wr_en_i = 1'b0;
  cfg_idx_t wr_idx_i = REG_FRAME_WIDTH;
  cfg_data_t wr_data_i = '0;

  gtp_coord_if coord_in ();
  gtp_pixel_if pixel_out ();

  gradient_test_pattern_pixel_unit uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en_i),
    .wr_idx_i  (wr_idx_i),
    .wr_data_i (wr_data_i),
    .coord_in  (coord_in.sink),
    .pixel_out (pixel_out.source)
  );

  always #1 clk_i = ~clk_i;

  // bench copy of the registers
  coord_t frame_w = RST_FRAME_WIDTH;
  coord_t frame_h = RST_FRAME_HEIGHT;
  logic   pix_fmt = FMT_RGB565;

  pixel_t pixel_q[$];
  int     n_errors = 0;
  int     n_pixels = 0;
  int     n_sent = 0;
  int     idle_cycles = 0;
  bit     hold_sink = 1'b0;
  bit     sink_idle = 1'b1;

  // colour of the gradient pattern at one coordinate
  function automatic pixel_t gradient_colour(coord_t px, coord_t py);
    logic [63:0] red, green, blue, dw, dh, ds, word;
    dw = (frame_w == '0) ? 64'd1 : 64'(frame_w);
    dh = (frame_h == '0) ? 64'd1 : 64'(frame_h);
    ds = 64'(frame_w) + 64'(frame_h);
    if (ds == 64'd0) ds = 64'd1;
    red   = (64'(px) * 64'd255) / dw;
    green = (64'(py) * 64'd255) / dh;
    blue  = (64'(px ^ py) * 64'd255) / ds;
    if (pix_fmt == FMT_XRGB8888) begin
      word = 64'hff000000 | (red << 16) | (green << 8) | blue;
      word &= 64'hffffffff;
    end else begin
      word = ((red & 64'hf8) << 8) | ((green & 64'hfc) << 3) | (blue >> 3);
      word &= 64'hffff;
    end
    return pixel_t'(word);
  endfunction

  task automatic report_mismatch(string what, pixel_t got, pixel_t want);
    $display("MISMATCH %s: got %08h want %08h", what, got, want);
    n_errors++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // output checker
  always @(posedge clk_i) begin
    if (rst_ni && pixel_out.valid && pixel_out.ready) begin
      if (pixel_q.size() == 0) report_mismatch("unexpected pixel", pixel_out.pixel_value, '0);
      else begin
        pixel_t want;
        want = pixel_q.pop_front();
        if (pixel_out.pixel_value !== want)
          report_mismatch("pixel_value", pixel_out.pixel_value, want);
        n_pixels++;
      end
    end
  end

  // sink ready with random stall stretches, or held off on request
  initial begin
    int g;
    g = 0;
    pixel_out.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        pixel_out.ready <= 1'b0;
      end else if (g > 0) begin
        pixel_out.ready <= 1'b0;
        g--;
      end else begin
        pixel_out.ready <= 1'b1;
        if (!sink_idle && $urandom_range(0, 3) == 0) g = gap_len();
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((coord_in.valid && coord_in.ready) || (pixel_out.valid && pixel_out.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("Watchdog expired");
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    @(posedge clk_i);
    wr_en_i   <= 1'b1;
    wr_idx_i  <= idx;
    wr_data_i <= val;
    @(posedge clk_i);
    wr_en_i   <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  frame_w = val;
      REG_FRAME_HEIGHT: frame_h = val;
      REG_PIXEL_FORMAT: pix_fmt = val[0];
      default: ;
    endcase
  endtask

  // withdraw the input offer after the last transfer
  task automatic stop_input();
    coord_in.valid <= 1'b0;
  endtask

  task automatic drain();
    stop_input();
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic set_frame(cfg_data_t w, cfg_data_t h, logic fmt);
    drain();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_PIXEL_FORMAT, cfg_data_t'(fmt));
  endtask

  // one coordinate transfer; valid stays up so the next can follow at once
  task automatic send_coord(coord_t px, coord_t py, bit with_gaps);
    int g;
    g = with_gaps ? gap_len() : 0;
    if (g > 0) begin
      coord_in.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    coord_in.valid <= 1'b1;
    coord_in.pos_x <= px;
    coord_in.pos_y <= py;
    pixel_q.push_back(gradient_colour(px, py));
    do @(posedge clk_i); while (!coord_in.ready);
    n_sent++;
  endtask

  task automatic test_reset_defaults();
    send_coord(12'd0, 12'd0, 0);
    send_coord(12'd639, 12'd479, 0);
    send_coord(12'd320, 12'd240, 0);
  endtask

  task automatic test_directed_extremes();
    logic fmt;
    for (int f = 0; f < 2; f++) begin
      fmt = f[0];
      set_frame(12'd4095, 12'd4095, fmt);
      send_coord(12'd0, 12'd4095, 0);
      send_coord(12'd4095, 12'd0, 0);
      send_coord(12'd4095, 12'd4095, 0);
      // zero width and height: every divisor becomes one
      set_frame(12'd0, 12'd0, fmt);
      send_coord(12'd4095, 12'd4095, 0);
      send_coord(12'd4095, 12'd0, 0);
      send_coord(12'd1, 12'd2, 0);
      // one dimension zero, far beyond the frame
      set_frame(12'd0, 12'd1, fmt);
      send_coord(12'd2730, 12'd1365, 0);
      set_frame(12'd1, 12'd0, fmt);
      send_coord(12'd1365, 12'd4095, 0);
    end
  endtask

  task automatic test_random_frames();
    cfg_data_t w, h;
    int n;
    for (int ph = 0; ph < 10; ph++) begin
      w = (ph % 3 == 0) ? cfg_data_t'($urandom_range(0, 15)) : cfg_data_t'($urandom);
      h = (ph % 4 == 1) ? cfg_data_t'($urandom_range(0, 15)) : cfg_data_t'($urandom);
      set_frame(w, h, ph[0]);
      sink_idle = (ph == 4);
      n = 100;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 1)) send_coord(coord_t'($urandom), coord_t'($urandom), ph != 4);
        else send_coord(coord_t'($urandom_range(0, w)), coord_t'($urandom_range(0, h)),
                        ph != 4);
      end
    end
    sink_idle = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    set_frame(12'd640, 12'd480, FMT_XRGB8888);
    fork
      begin
        hold_sink = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 120; i++) send_coord(coord_t'($urandom), coord_t'($urandom), 0);
    join
    stop_input();
    // sender waits for the output to empty before carrying on
    while (pixel_q.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 120; i++) send_coord(coord_t'($urandom), coord_t'($urandom), 1);
  endtask

  initial begin
    coord_in.valid = 1'b0;
    coord_in.pos_x = '0;
    coord_in.pos_y = '0;
    sink_idle = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_directed_extremes();
    test_random_frames();
    test_backpressure();
    drain();
    if (pixel_q.size() != 0) begin
      $display("%0d pixels never arrived", pixel_q.size());
      n_errors++;
    end
    $display("Sent %0d coordinates over extreme, zero and random frame sizes in both",
             n_sent);
    $display("formats with back-pressure; %0d pixels checked, %0d errors",
             n_pixels, n_errors);
    if (n_errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
